/* rtl/random_cyclic_chain_generator_core_macros.svh */
// Assertion helpers used by the RTL core.
`ifndef RANDOM_CYCLIC_CHAIN_GENERATOR_CORE_MACROS_SVH
`define RANDOM_CYCLIC_CHAIN_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RCCG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rccg assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RCCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rccg assertion failed");

`endif

/* rtl/rccg_pkg.sv */
package rccg_pkg;

    localparam int MAX_PAGES = 64;
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SEED_W    = 64;
    localparam int PCNT_W    = 7;
    localparam int OUT_IDX_W = 6;

    localparam int IN_W  = ((SEED_W + PCNT_W + 7) / 8) * 8;
    localparam int OUT_W = ((3 * OUT_IDX_W + SEED_W + 7) / 8) * 8;

    localparam logic [SEED_W-1:0] DEFAULT_GEN_SEED = 64'd20260824;
    localparam logic [SEED_W-1:0] MARKER_KEY       = 64'h43594c3031424e55;

    localparam int SH_A = 13;
    localparam int SH_B = 7;
    localparam int SH_C = 17;

    function automatic logic [SEED_W-1:0] xorshift64(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] v;
        v = s;
        v = v ^ (v << SH_A);
        v = v ^ (v >> SH_B);
        v = v ^ (v << SH_C);
        return v;
    endfunction

endpackage

/* rtl/rccg_mod.sv */
// Bit-serial restoring remainder: one dividend bit per cycle.
module rccg_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rccg_pkg::SEED_W-1:0]  i_dividend,
    input  logic [rccg_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [rccg_pkg::IDX_W-1:0]   o_rem
);

    localparam int CT_W = $clog2(rccg_pkg::SEED_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CT_W-1:0]             r_ct;
    logic [rccg_pkg::SEED_W-1:0] r_dvd;
    logic [rccg_pkg::CNT_W-1:0]  r_d;
    logic [rccg_pkg::IDX_W-1:0]  r_rem;

    logic [rccg_pkg::CNT_W-1:0]  trial;
    logic [rccg_pkg::CNT_W-1:0]  diff;
    logic [rccg_pkg::IDX_W-1:0]  n_rem;

    // remainder stays below the divisor (<= MAX_PAGES), so IDX_W bits hold it
    assign trial = {r_rem, r_dvd[rccg_pkg::SEED_W-1]};
    assign diff  = trial - r_d;
    assign n_rem = (trial >= r_d) ? diff[rccg_pkg::IDX_W-1:0]
                                  : trial[rccg_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ct   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ct   <= '0;
            end else if (r_busy) begin
                r_ct <= r_ct + CT_W'(1);
                if (r_ct == CT_W'(rccg_pkg::SEED_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[rccg_pkg::SEED_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* rtl/random_cyclic_chain_generator_core.sv */
// Channel   Dir  Contents
// s_axis    in   tdata: seed[63:0], page_count[70:64]
// m_axis    out  tdata: position[5:0], page[11:6], next_page[17:12],
//                marker[81:18]; tlast marks the final link
//
// One request at a time. The request is accepted and the permutation memory is
// filled; then each of the n-1 shuffle steps runs one generator step, the
// serial remainder unit and four single-port accesses to the permutation
// memory; emission follows, one link at a time.
// A page count of zero gives no links; counts above 64 act as 64.
// Reset is synchronous, active low; the memory holds no reset state.
// A stalled m_axis halts emission; the next request may enter while the last
// link still waits in the output register.
`include "random_cyclic_chain_generator_core_macros.svh"

module random_cyclic_chain_generator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rccg_pkg::IN_W-1:0]   s_axis_tdata,   // seed, page_count
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rccg_pkg::OUT_W-1:0]  m_axis_tdata,   // position, page,
                                                        // next_page, marker
    output logic                        m_axis_tlast
);

    localparam int IDX_W  = rccg_pkg::IDX_W;
    localparam int CNT_W  = rccg_pkg::CNT_W;
    localparam int SEED_W = rccg_pkg::SEED_W;
    localparam int PAD_W  = rccg_pkg::OUT_W - 3 * rccg_pkg::OUT_IDX_W - SEED_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_GEN  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_RDI  = 4'd4;
    localparam logic [3:0] S_RDP  = 4'd5;
    localparam logic [3:0] S_WRI  = 4'd6;
    localparam logic [3:0] S_WRP  = 4'd7;
    localparam logic [3:0] S_EM0  = 4'd8;
    localparam logic [3:0] S_EM1  = 4'd9;
    localparam logic [3:0] S_EMR  = 4'd10;
    localparam logic [3:0] S_EMO  = 4'd11;

    logic [3:0]              r_state;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_pick;
    logic [IDX_W-1:0]        r_a;
    logic [IDX_W-1:0]        r_first;
    logic [IDX_W-1:0]        r_cur;
    logic [SEED_W-1:0]       r_seed;
    logic [SEED_W-1:0]       r_rng;

    logic [IDX_W-1:0]        r_store [rccg_pkg::MAX_PAGES];
    logic [IDX_W-1:0]        r_rd_data;

    logic                    r_ov;
    logic [rccg_pkg::OUT_IDX_W-1:0] r_o_pos;
    logic [rccg_pkg::OUT_IDX_W-1:0] r_o_page;
    logic [rccg_pkg::OUT_IDX_W-1:0] r_o_next;
    logic [SEED_W-1:0]       r_o_marker;
    logic                    r_o_last;

    logic                    in_xfer;
    logic [SEED_W-1:0]       in_seed;
    logic [CNT_W-1:0]        in_count;
    logic [CNT_W-1:0]        in_n;
    logic [CNT_W-1:0]        n_m1;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    emit_wrap;
    logic [IDX_W-1:0]        nxt;
    logic [SEED_W-1:0]       gen_val;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        wr_data;
    logic                    out_load;

    logic                    div_start;
    logic                    div_done;
    logic [IDX_W-1:0]        div_rem;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_seed       = s_axis_tdata[SEED_W-1:0];
    assign in_count      = s_axis_tdata[SEED_W +: rccg_pkg::PCNT_W];
    assign in_n          = (in_count > CNT_W'(rccg_pkg::MAX_PAGES))
                           ? CNT_W'(rccg_pkg::MAX_PAGES) : in_count;

    assign n_m1      = r_n - CNT_W'(1);
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign emit_wrap = (cnt_inc == r_n);
    assign nxt       = emit_wrap ? r_first : r_rd_data;
    assign gen_val   = rccg_pkg::xorshift64(r_rng);
    assign div_start = (r_state == S_GEN);

    rccg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (gen_val),
        .i_divisor  ({1'b0, r_i} + CNT_W'(1)),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // single-port memory access schedule; each state touches at most one entry
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        out_load = 1'b0;
        unique case (r_state)
            S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[IDX_W-1:0];
                wr_data = r_cnt[IDX_W-1:0];
            end
            S_RDI: begin
                rd_en   = 1'b1;
                rd_addr = r_i;
            end
            S_RDP: begin
                rd_en   = 1'b1;
                rd_addr = r_pick;
            end
            S_WRI: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_rd_data;
            end
            S_WRP: begin
                wr_en   = 1'b1;
                wr_addr = r_pick;
                wr_data = r_a;
            end
            S_EM0: begin
                rd_en = 1'b1;
            end
            S_EMR: begin
                rd_en   = !emit_wrap;
                rd_addr = cnt_inc[IDX_W-1:0];
            end
            S_EMO: begin
                out_load = !r_ov || m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_n     <= '0;
            r_cnt   <= '0;
            r_i     <= '0;
            r_rng   <= '0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_n   <= in_n;
                        r_cnt <= '0;
                        r_rng <= (in_seed == '0) ? rccg_pkg::DEFAULT_GEN_SEED : in_seed;
                        if (in_n != '0) begin
                            r_state <= S_FILL;
                        end
                    end
                end
                S_FILL: begin
                    r_cnt <= cnt_inc;
                    if (r_cnt == n_m1) begin
                        if (r_n == CNT_W'(1)) begin
                            r_state <= S_EM0;
                        end else begin
                            r_i     <= n_m1[IDX_W-1:0];
                            r_state <= S_GEN;
                        end
                    end
                end
                S_GEN: begin
                    r_rng   <= gen_val;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_RDI;
                    end
                end
                S_RDI: r_state <= S_RDP;
                S_RDP: r_state <= S_WRI;
                S_WRI: r_state <= S_WRP;
                S_WRP: begin
                    if (r_i == IDX_W'(1)) begin
                        r_state <= S_EM0;
                    end else begin
                        r_i     <= r_i - IDX_W'(1);
                        r_state <= S_GEN;
                    end
                end
                S_EM0: r_state <= S_EM1;
                S_EM1: begin
                    r_cnt   <= '0;
                    r_state <= S_EMR;
                end
                S_EMR: r_state <= S_EMO;
                S_EMO: begin
                    if (out_load) begin
                        r_cnt   <= cnt_inc;
                        r_state <= emit_wrap ? S_IDLE : S_EMR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_seed <= in_seed;
        end
        if (r_state == S_DIV && div_done) begin
            r_pick <= div_rem;
        end
        if (r_state == S_RDP) begin
            r_a <= r_rd_data;
        end
        if (r_state == S_EM1) begin
            r_first <= r_rd_data;
            r_cur   <= r_rd_data;
        end
        if (out_load) begin
            r_cur      <= nxt;
            r_o_pos    <= rccg_pkg::OUT_IDX_W'(r_cnt[IDX_W-1:0]);
            r_o_page   <= rccg_pkg::OUT_IDX_W'(r_cur);
            r_o_next   <= rccg_pkg::OUT_IDX_W'(nxt);
            r_o_marker <= SEED_W'(r_cur) ^ r_seed ^ rccg_pkg::MARKER_KEY;
            r_o_last   <= emit_wrap;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_o_marker, r_o_next, r_o_page, r_o_pos};
    assign m_axis_tlast  = r_o_last;

    `RCCG_ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `RCCG_ASSERT_IMPL(a_pick_in_range, i_clk, i_rst_n, r_state == S_RDI, r_pick <= r_i)
    `RCCG_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, out_load && emit_wrap, r_state == S_IDLE)
    `RCCG_ASSERT_NEXT(a_empty_request, i_clk, i_rst_n, in_xfer && in_n == '0, r_state == S_IDLE)

endmodule
